// ===== rtl/core/smt_pkg.sv =====
package smt_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam int ID_W      = 8;
    localparam int MASK_W    = 16;
    localparam int STAMP_W   = 8;
    localparam int TIMER_W   = 9;
    localparam int CMD_W     = 3;
    localparam int BIT_W     = 4;
    localparam int LIVE_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [LIVE_W-1:0] LIVE_MAX = 5'd31;

    localparam logic [CMD_W-1:0] CMD_LIST  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PING  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_JOIN  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LEAVE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAMP_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_INIT = 2'd2;

    localparam logic [ID_W-1:0]    RST_LOCAL_ID   = 8'd0;
    localparam logic [STAMP_W-1:0] RST_STAMP_THR  = 8'd40;
    localparam logic [TIMER_W-1:0] RST_TIMER_INIT = 9'd500;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [MASK_W-1:0]  mask;
        logic [STAMP_W-1:0] stamp;
        logic [TIMER_W-1:0] timer;
    } t_rec;

endpackage

// ===== rtl/core/smt_table.sv =====
module smt_table #(
    parameter int ENTRIES = smt_pkg::DEF_ENTRIES,
    parameter int AW      = $clog2(ENTRIES)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output smt_pkg::t_rec     o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  smt_pkg::t_rec     i_wr_data
);
    import smt_pkg::*;

    t_rec r_mem [ENTRIES];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/swarm_membership_table.sv =====
// A result is registered after the stored entries are scanned, one per cycle; a search
// that matches at slot p stops early. Unused commands skip the scan.
// One transaction in flight; the next is taken the cycle after the result is registered.
// A stalled result holds the update cycle.
// Synchronous active-low reset empties the table by clearing the entry count; record
// storage is not cleared and no sweep is needed.
module swarm_membership_table #(
    parameter int ENTRIES = smt_pkg::DEF_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [smt_pkg::CMD_W-1:0]     i_cmd,
    input  logic [smt_pkg::ID_W-1:0]      i_robot_id,
    input  logic [smt_pkg::MASK_W-1:0]    i_swarm_mask,
    input  logic [smt_pkg::STAMP_W-1:0]   i_stamp,
    input  logic [smt_pkg::BIT_W-1:0]     i_swarm_bit,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_accepted,
    output logic                          o_table_full,
    output logic                          o_relay,
    output logic [smt_pkg::LIVE_W-1:0]    o_live_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [smt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [smt_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import smt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = (CW > LIVE_W) ? CW : LIVE_W;

    typedef enum logic [1:0] {S_IDLE, S_SRCH, S_TICK, S_DEC} t_state;

    t_state              r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [ID_W-1:0]     r_id, n_id;
    logic [MASK_W-1:0]   r_mask, n_mask;
    logic [STAMP_W-1:0]  r_stamp, n_stamp;
    logic [ID_W-1:0]     r_key, n_key;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_pend, n_pend;
    logic [AW-1:0]       r_pend_addr, n_pend_addr;
    logic                r_found, n_found;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_live, n_live;
    logic [MASK_W-1:0]   r_own_mask, n_own_mask;
    logic [STAMP_W-1:0]  r_own_stamp, n_own_stamp;
    logic [ID_W-1:0]     r_local_id;
    logic [STAMP_W-1:0]  r_stamp_thr;
    logic [TIMER_W-1:0]  r_timer_init;
    logic                r_out_vld, n_out_vld;
    logic                r_out_acc, n_out_acc;
    logic                r_out_full, n_out_full;
    logic                r_out_relay, n_out_relay;
    logic [LIVE_W-1:0]   r_out_live, n_out_live;

    logic                rd_en;
    t_rec                rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_rec                wr_data;

    logic                hit, issue, go;
    logic                is_net, is_own, newer, wr_ok, room, ping_refresh;
    logic [STAMP_W-1:0]  stamp_diff;
    logic [TIMER_W-1:0]  new_timer;

    function automatic logic [LIVE_W-1:0] live_sat(input logic [CW-1:0] v);
        logic [LW-1:0] ext;
        ext = LW'(v);
        return (ext > LW'(LIVE_MAX)) ? LIVE_MAX : ext[LIVE_W-1:0];
    endfunction

    smt_table #(.ENTRIES(ENTRIES), .AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[AW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_vld;
    assign o_accepted   = r_out_acc;
    assign o_table_full = r_out_full;
    assign o_relay      = r_out_relay;
    assign o_live_count = r_out_live;

    assign hit   = (r_state == S_SRCH) && r_pend && (rd_data.id == r_key);
    assign issue = ((r_state == S_SRCH) || (r_state == S_TICK)) &&
                   (r_addr < r_count) && !hit;
    assign rd_en = issue;
    assign go    = !r_out_vld || i_out_ready;

    assign is_net       = (r_cmd inside {CMD_LIST, CMD_PING});
    assign is_own       = (r_cmd inside {CMD_JOIN, CMD_LEAVE});
    assign stamp_diff   = r_stamp - rd_data.stamp;
    assign newer        = !r_found || (stamp_diff > r_stamp_thr);
    assign wr_ok        = is_own ||
                          (is_net && newer && ((r_cmd == CMD_LIST) || (r_id != r_local_id)));
    assign room         = (r_count < CW'(ENTRIES));
    assign ping_refresh = (r_cmd == CMD_PING) && r_found;
    assign new_timer    = (r_cmd == CMD_PING) ? r_timer_init : rd_data.timer;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_mask      = r_mask;
        n_stamp     = r_stamp;
        n_key       = r_key;
        n_addr      = r_addr;
        n_pend      = r_pend;
        n_pend_addr = r_pend_addr;
        n_found     = r_found;
        n_pos       = r_pos;
        n_count     = r_count;
        n_live      = r_live;
        n_own_mask  = r_own_mask;
        n_own_stamp = r_own_stamp;
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out_acc   = r_out_acc;
        n_out_full  = r_out_full;
        n_out_relay = r_out_relay;
        n_out_live  = r_out_live;
        wr_en       = 1'b0;
        wr_addr     = r_pos;
        wr_data     = rd_data;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_id    = i_robot_id;
                    n_mask  = i_swarm_mask;
                    n_stamp = i_stamp;
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_key   = i_robot_id;
                    case (i_cmd)
                        CMD_LIST, CMD_PING: n_state = S_SRCH;
                        CMD_TICK:           n_state = S_TICK;
                        CMD_JOIN: begin
                            n_own_mask  = r_own_mask | (MASK_W'(1) << i_swarm_bit);
                            n_own_stamp = r_own_stamp + STAMP_W'(1);
                            n_key       = r_local_id;
                            n_state     = S_SRCH;
                        end
                        CMD_LEAVE: begin
                            n_own_mask  = r_own_mask & ~(MASK_W'(1) << i_swarm_bit);
                            n_own_stamp = r_own_stamp + STAMP_W'(1);
                            n_key       = r_local_id;
                            n_state     = S_SRCH;
                        end
                        default:            n_state = S_DEC;
                    endcase
                end
            end
            S_SRCH: begin
                n_pend      = issue;
                n_pend_addr = r_addr[AW-1:0];
                if (issue) begin
                    n_addr = r_addr + CW'(1);
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_pos   = r_pend_addr;
                    n_state = S_DEC;
                end else if (!issue && !r_pend) begin
                    n_state = S_DEC;
                end
            end
            S_TICK: begin
                n_pend      = issue;
                n_pend_addr = r_addr[AW-1:0];
                if (issue) begin
                    n_addr = r_addr + CW'(1);
                end
                if (r_pend && (rd_data.timer != '0)) begin
                    wr_en         = 1'b1;
                    wr_addr       = r_pend_addr;
                    wr_data.timer = rd_data.timer - TIMER_W'(1);
                    if (rd_data.timer == TIMER_W'(1)) begin
                        n_live = r_live - CW'(1);
                    end
                end
                if (!issue && !r_pend) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (go) begin
                    if (is_own) begin
                        wr_data.id    = r_local_id;
                        wr_data.mask  = r_own_mask;
                        wr_data.stamp = r_own_stamp;
                    end else begin
                        wr_data.id    = r_id;
                        wr_data.mask  = r_mask;
                        wr_data.stamp = r_stamp;
                    end
                    if (r_found) begin
                        if (wr_ok || ping_refresh) begin
                            wr_en   = 1'b1;
                            wr_addr = r_pos;
                            if (!wr_ok) begin
                                wr_data.mask  = rd_data.mask;
                                wr_data.stamp = rd_data.stamp;
                            end
                            wr_data.id    = rd_data.id;
                            wr_data.timer = new_timer;
                            if ((new_timer != '0) && (rd_data.timer == '0)) begin
                                n_live = r_live + CW'(1);
                            end else if ((new_timer == '0) && (rd_data.timer != '0)) begin
                                n_live = r_live - CW'(1);
                            end
                        end
                    end else if (wr_ok && room) begin
                        wr_en         = 1'b1;
                        wr_addr       = r_count[AW-1:0];
                        wr_data.timer = r_timer_init;
                        n_count       = r_count + CW'(1);
                        if (r_timer_init != '0) begin
                            n_live = r_live + CW'(1);
                        end
                    end
                    n_out_vld   = 1'b1;
                    n_out_acc   = wr_ok && (r_found || room);
                    n_out_full  = wr_ok && !r_found && !room;
                    n_out_relay = wr_ok && (r_found || room) && (r_cmd == CMD_PING);
                    n_out_live  = live_sat(n_live);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend       <= 1'b0;
            r_found      <= 1'b0;
            r_count      <= '0;
            r_live       <= '0;
            r_own_mask   <= '0;
            r_own_stamp  <= '0;
            r_local_id   <= RST_LOCAL_ID;
            r_stamp_thr  <= RST_STAMP_THR;
            r_timer_init <= RST_TIMER_INIT;
            r_out_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd       <= n_cmd;
            r_id        <= n_id;
            r_mask      <= n_mask;
            r_stamp     <= n_stamp;
            r_key       <= n_key;
            r_addr      <= n_addr;
            r_pend      <= n_pend;
            r_pend_addr <= n_pend_addr;
            r_found     <= n_found;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_live      <= n_live;
            r_own_mask  <= n_own_mask;
            r_own_stamp <= n_own_stamp;
            r_out_vld   <= n_out_vld;
            r_out_acc   <= n_out_acc;
            r_out_full  <= n_out_full;
            r_out_relay <= n_out_relay;
            r_out_live  <= n_out_live;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LOCAL_ID:   r_local_id   <= i_cfg_data[ID_W-1:0];
                    CFG_STAMP_THR:  r_stamp_thr  <= i_cfg_data[STAMP_W-1:0];
                    CFG_TIMER_INIT: r_timer_init <= i_cfg_data[TIMER_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/smt_checker.sv =====
module smt_checker #(
    parameter int ENTRIES = smt_pkg::DEF_ENTRIES
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic                        o_accepted,
    input logic                        o_table_full,
    input logic                        o_relay,
    input logic [smt_pkg::LIVE_W-1:0]  o_live_count
);
    import smt_pkg::*;

    localparam int LIVE_CAP = (ENTRIES > 31) ? 31 : ENTRIES;

    // one transaction in flight at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous transaction still in work");

    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_live_count) <= LIVE_CAP))
        else $error("live count exceeds table size");

    a_acc_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_accepted && o_table_full))
        else $error("result both accepted and dropped");

    a_relay_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_relay) |-> o_accepted)
        else $error("relay without a written entry");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_live_count)))
        else $error("stalled result changed");

endmodule

bind swarm_membership_table smt_checker #(.ENTRIES(ENTRIES)) u_smt_checker (.*);
